FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the encoder learning update RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the following edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/elu_pkg.sv
// Types, constants and fixed-point helpers for the encoder learning update
package elu_pkg;

    localparam int DATA_W            = 32;
    localparam int NEURON_W          = 8;
    localparam int DIM_W             = 4;
    localparam int FRAC_BITS         = 15;
    localparam int NEURONS_DEF       = 256;
    localparam int ENCODER_WIDTH_DEF = 16;
    localparam int PIPE_LATENCY      = 6;

    localparam logic signed [DATA_W-1:0] INV_RADIUS_RESET = 32'sd32768;

    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_UPDATE = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                     command;
        logic [NEURON_W-1:0]      neuron;
        logic [DIM_W-1:0]         dimension;
        logic signed [DATA_W-1:0] rate;
        logic signed [DATA_W-1:0] activity;
        logic signed [DATA_W-1:0] gain;
        logic signed [DATA_W-1:0] signal;
    } in_word_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0] element_value;
        logic                     saturated;
    } out_word_t;

    // 16.15 product, floor of the exact product over 2^15, wrapped to 32 bits
    function automatic logic signed [DATA_W-1:0] mul_q15(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [2*DATA_W-1:0] p;
        p = a * b;
        return p[FRAC_BITS +: DATA_W];
    endfunction

endpackage

FILE: rtl/core/encoder_learning_update.sv
// Encoder learning update: top level with inverse-radius register, pipeline and store
//
// Use: drive start with an input word on item; the word is taken at a rising
// edge where start is high and busy is low. command CMD_LOAD writes signal
// into the element addressed by neuron and dimension; CMD_UPDATE applies
// e += t*signal - s*e with s = rate*activity, t = s*gain*inverse_radius.
// Every taken word gives one result word on result, flagged by done for one
// cycle as it leaves the last pipeline stage. The receiver cannot stall.
// One word per cycle is taken; busy only rises for an update whose element
// was also the target of an update taken on the cycle before, because the
// store read-modify-write loop (multiply, then add and saturate) has not
// yet registered the new value when the next update needs it. Words whose
// neuron or dimension lies out of range store nothing and return zero.
// inverse_radius is written at any edge with inverse_radius_we high; write it
// only while idle, the block does not check this. Reset empties the pipeline
// and sets inverse_radius to 1.0; store contents stay undefined until loaded.
module encoder_learning_update
    import elu_pkg::*;
#(
    parameter int NEURONS       = NEURONS_DEF,
    parameter int ENCODER_WIDTH = ENCODER_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  in_word_t                 item,
    output logic                     done,
    output out_word_t                result,
    input  logic                     inverse_radius_we,
    input  logic signed [DATA_W-1:0] inverse_radius_wdata
);

    localparam int DEPTH  = NEURONS * ENCODER_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [DATA_W-1:0] inverse_radius_reg;
    logic signed [DATA_W-1:0] inverse_radius_next;

    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]        mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;

    assign inverse_radius_next = inverse_radius_we ? inverse_radius_wdata
                                                   : inverse_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_radius_reg <= INV_RADIUS_RESET;
        end
        else
        begin
            inverse_radius_reg <= inverse_radius_next;
        end
    end

    elu_pipe #(
        .NEURONS       (NEURONS),
        .ENCODER_WIDTH (ENCODER_WIDTH),
        .DEPTH         (DEPTH),
        .ADDR_W        (ADDR_W)
    ) u_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .inverse_radius (inverse_radius_reg),
        .done           (done),
        .result         (result),
        .mem_we         (mem_we),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    elu_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

FILE: rtl/core/elu_store.sv
// Encoder element memory: one write port, one registered read port
module elu_store
    import elu_pkg::*;
#(
    parameter int DEPTH  = NEURONS_DEF * ENCODER_WIDTH_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0]        raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // read returns the old contents when the same entry is written this edge
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = $signed(rdata_reg);

endmodule

FILE: rtl/core/elu_pipe.sv
// Six-stage update pipeline: multiplies, store read-modify-write, forwarding, interlock
`include "assert_macros.svh"

module elu_pipe
    import elu_pkg::*;
#(
    parameter int NEURONS       = NEURONS_DEF,
    parameter int ENCODER_WIDTH = ENCODER_WIDTH_DEF,
    parameter int DEPTH         = NEURONS * ENCODER_WIDTH,
    parameter int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  in_word_t                 item,
    input  logic signed [DATA_W-1:0] inverse_radius,
    output logic                     done,
    output out_word_t                result,
    output logic                     mem_we,
    output logic [ADDR_W-1:0]        mem_waddr,
    output logic signed [DATA_W-1:0] mem_wdata,
    output logic [ADDR_W-1:0]        mem_raddr,
    input  logic signed [DATA_W-1:0] mem_rdata
);

    // incoming word decode
    logic              in_ok;
    logic              in_upd;
    logic [ADDR_W-1:0] in_addr;
    logic              accept;

    // stage valid / control
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic u1_reg, u2_reg, u3_reg, u4_reg, u5_reg;
    logic ok1_reg, ok2_reg, ok3_reg, ok4_reg, ok5_reg, ok6_reg;
    logic [ADDR_W-1:0] a1_reg, a2_reg, a3_reg, a4_reg, a5_reg, a6_reg;

    // stage payload
    logic signed [DATA_W-1:0] rate1_reg, act1_reg, gain1_reg, gain2_reg;
    logic signed [DATA_W-1:0] sig1_reg, sig2_reg, sig3_reg, sig4_reg, sig5_reg;
    logic signed [DATA_W-1:0] s2_reg, s3_reg, s4_reg;
    logic signed [DATA_W-1:0] sg3_reg, t4_reg;
    logic signed [DATA_W-1:0] p1_5_reg, p2_5_reg, e5_reg;
    out_word_t                res6_reg;

    logic signed [DATA_W-1:0] e4_next;
    logic signed [DATA_W+1:0] sum5;
    out_word_t                res6_next;

    assign in_ok   = (32'(item.neuron) < NEURONS) && (32'(item.dimension) < ENCODER_WIDTH);
    assign in_upd  = (item.command == CMD_UPDATE);
    assign in_addr = ADDR_W'(32'(item.neuron) * ENCODER_WIDTH + 32'(item.dimension));

    // an update cannot directly follow an update of the same element:
    // the value it needs is still in the sum stage when it reaches stage 4
    assign busy   = start && in_upd && in_ok && v1_reg && u1_reg && ok1_reg
                    && (a1_reg == in_addr);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // element value for stage 4: newer writes still in flight win over memory
    always_comb
    begin
        if (v5_reg && ok5_reg && !u5_reg && (a5_reg == a4_reg))
        begin
            e4_next = sig5_reg;
        end
        else if (v6_reg && ok6_reg && (a6_reg == a4_reg))
        begin
            e4_next = res6_reg.element_value;
        end
        else
        begin
            e4_next = mem_rdata;
        end
    end

    assign sum5 = {{2{e5_reg[DATA_W-1]}}, e5_reg}
                + {{2{p1_5_reg[DATA_W-1]}}, p1_5_reg}
                - {{2{p2_5_reg[DATA_W-1]}}, p2_5_reg};

    always_comb
    begin
        res6_next.element_value = '0;
        res6_next.saturated     = 1'b0;
        if (ok5_reg)
        begin
            if (!u5_reg)
            begin
                res6_next.element_value = sig5_reg;
            end
            else if (sum5[DATA_W+1:DATA_W-1] == 3'b000 || sum5[DATA_W+1:DATA_W-1] == 3'b111)
            begin
                res6_next.element_value = sum5[DATA_W-1:0];
            end
            else
            begin
                res6_next.saturated     = 1'b1;
                res6_next.element_value = sum5[DATA_W+1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                         : {1'b0, {(DATA_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: capture
        u1_reg    <= in_upd;
        ok1_reg   <= in_ok;
        a1_reg    <= in_addr;
        rate1_reg <= item.rate;
        act1_reg  <= item.activity;
        gain1_reg <= item.gain;
        sig1_reg  <= item.signal;
        // stage 2: s = rate * activity
        u2_reg    <= u1_reg;
        ok2_reg   <= ok1_reg;
        a2_reg    <= a1_reg;
        s2_reg    <= mul_q15(rate1_reg, act1_reg);
        gain2_reg <= gain1_reg;
        sig2_reg  <= sig1_reg;
        // stage 3: s * gain
        u3_reg    <= u2_reg;
        ok3_reg   <= ok2_reg;
        a3_reg    <= a2_reg;
        s3_reg    <= s2_reg;
        sg3_reg   <= mul_q15(s2_reg, gain2_reg);
        sig3_reg  <= sig2_reg;
        // stage 4: t = s * gain * inverse_radius; store read lands here
        u4_reg    <= u3_reg;
        ok4_reg   <= ok3_reg;
        a4_reg    <= a3_reg;
        s4_reg    <= s3_reg;
        t4_reg    <= mul_q15(sg3_reg, inverse_radius);
        sig4_reg  <= sig3_reg;
        // stage 5: t * signal and s * e
        u5_reg    <= u4_reg;
        ok5_reg   <= ok4_reg;
        a5_reg    <= a4_reg;
        sig5_reg  <= sig4_reg;
        e5_reg    <= e4_next;
        p1_5_reg  <= mul_q15(t4_reg, sig4_reg);
        p2_5_reg  <= mul_q15(s4_reg, e4_next);
        // stage 6: saturated sum, result word
        ok6_reg   <= ok5_reg;
        a6_reg    <= a5_reg;
        res6_reg  <= res6_next;
    end

    assign mem_raddr = a3_reg;
    assign mem_we    = v5_reg && ok5_reg;
    assign mem_waddr = a5_reg;
    assign mem_wdata = res6_next.element_value;

    assign done   = v6_reg;
    assign result = res6_reg;

    `ASSERT_CLK(a_no_raw_gap, !(v4_reg && u4_reg && ok4_reg && v5_reg && u5_reg && ok5_reg && (a4_reg == a5_reg)), "update of an element entered stage 4 while its previous update was summing")
    `ASSERT_CLK(a_latency, (start && !busy) |-> ##6 done, "result strobe missing six cycles after acceptance")
    `ASSERT_NEXT(a_write_in_range, mem_we, (32'(a6_reg) < DEPTH) && ok6_reg, "store write outside the element range")

endmodule
